[hw/rtl/lsi_pkg.sv]
package lsi_pkg;

   localparam int CW = 32;          // coordinate width
   localparam int DW = CW + 1;      // endpoint difference
   localparam int PW = 2 * DW;      // difference product
   localparam int SW = PW + 1;      // cross-product sum
   localparam int MW = PW;          // magnitude of a cross product
   localparam int QB = CW + 2;      // quotient bits kept before clamping
   localparam int NW = DW + MW;     // magnitude of offset numerator
   localparam int RW = MW;          // divider remainder

   localparam logic [QB:0] MAG_LIMIT = (QB+1)'(1) << (CW + 1);

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_BOUNDED   = 2'd1,
      KIND_UNBOUNDED = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [CW-1:0] first_start_x;
      logic signed [CW-1:0] first_start_y;
      logic signed [CW-1:0] first_end_x;
      logic signed [CW-1:0] first_end_y;
      logic signed [CW-1:0] other_start_x;
      logic signed [CW-1:0] other_start_y;
      logic signed [CW-1:0] other_end_x;
      logic signed [CW-1:0] other_end_y;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
      logic                 point_valid;
      logic                 point_saturated;
   } rsp_type;

   typedef struct packed {
      kind_type             kind;
      logic signed [CW-1:0] start;
      logic                 neg;
   } side_type;

endpackage

[hw/rtl/line_segment_intersect.sv]
// Segment intersection, one word per cycle. Assert start with the two
// segments on req_word; busy is always low, so every start is taken. The
// answer appears on rsp_word with rsp_strobe high for one cycle, after 6
// cross-product stages, 35 divider stages (a load stage, then one quotient
// bit per stage) and 2 rounding/saturation stages. The receiver cannot stall
// and must take every word as it comes. Results leave in the order words entered.
module line_segment_intersect import lsi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   logic          f_valid;
   logic [NW-1:0] f_num_x, f_num_y;
   logic [MW-1:0] f_den;
   side_type      f_side_x, f_side_y;

   logic          dx_valid, dy_valid;
   logic [QB-1:0] dx_quo, dy_quo;
   logic [RW-1:0] dx_rem, dy_rem;
   logic [MW-1:0] dx_den, dy_den;
   logic          dx_big, dy_big;
   side_type      dx_side, dy_side;

   logic signed [CW-1:0] px, py;
   logic                 sx, sy;

   logic [1:0]    v_ff;
   kind_type      k1_ff, k2_ff;
   rsp_type       rsp_in;

   assign busy = 1'b0;

   lsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_word   (req_word),
      .out_valid (f_valid),
      .num_x     (f_num_x),
      .num_y     (f_num_y),
      .den_mag   (f_den),
      .side_x    (f_side_x),
      .side_y    (f_side_y)
   );

   lsi_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .num       (f_num_x),
      .den       (f_den),
      .in_side   (f_side_x),
      .out_valid (dx_valid),
      .quo       (dx_quo),
      .rem       (dx_rem),
      .den_out   (dx_den),
      .big       (dx_big),
      .out_side  (dx_side)
   );

   lsi_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .num       (f_num_y),
      .den       (f_den),
      .in_side   (f_side_y),
      .out_valid (dy_valid),
      .quo       (dy_quo),
      .rem       (dy_rem),
      .den_out   (dy_den),
      .big       (dy_big),
      .out_side  (dy_side)
   );

   lsi_place u_place_x (
      .clock (clock),
      .quo   (dx_quo),
      .rem   (dx_rem),
      .den   (dx_den),
      .big   (dx_big),
      .side  (dx_side),
      .point (px),
      .sat   (sx)
   );

   lsi_place u_place_y (
      .clock (clock),
      .quo   (dy_quo),
      .rem   (dy_rem),
      .den   (dy_den),
      .big   (dy_big),
      .side  (dy_side),
      .point (py),
      .sat   (sy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[0], dx_valid};
      end
   end

   // kind rides with x; y carries the same copy
   always_ff @(posedge clock) begin
      k1_ff <= (dx_side.kind == dy_side.kind) ? dx_side.kind : KIND_NONE;
      k2_ff <= k1_ff;
   end

   always_comb begin
      rsp_in.kind = k2_ff;
      if (k2_ff == KIND_NONE) begin
         rsp_in.point_x         = '0;
         rsp_in.point_y         = '0;
         rsp_in.point_valid     = 1'b0;
         rsp_in.point_saturated = 1'b0;
      end else begin
         rsp_in.point_x         = px;
         rsp_in.point_y         = py;
         rsp_in.point_valid     = 1'b1;
         rsp_in.point_saturated = sx | sy;
      end
   end

   assign rsp_strobe = v_ff[1];
   assign rsp_word   = rsp_in;

`ifndef SYNTHESIS
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dx_valid == dy_valid)
      else $error("divider lanes out of step");

   a_valid_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.point_valid == (rsp_word.kind != KIND_NONE)))
      else $error("point_valid disagrees with kind");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.kind == KIND_NONE) |->
         (rsp_word.point_x == '0 && rsp_word.point_y == '0 && !rsp_word.point_saturated))
      else $error("parallel result carries a point");

   a_strobe_from_div: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(dx_valid, 2))
      else $error("result word without divider word");
`endif

endmodule

[hw/rtl/lsi_front.sv]
module lsi_front import lsi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_type         in_word,
   output logic            out_valid,
   output logic [NW-1:0]   num_x,
   output logic [NW-1:0]   num_y,
   output logic [MW-1:0]   den_mag,
   output side_type        side_x,
   output side_type        side_y
);

   logic [5:0] v_ff;

   // stage 1: differences
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [CW-1:0] sx1_ff, sy1_ff;
   // stage 2: products
   logic signed [PW-1:0] aybx_ff, axby_ff, bycx_ff, bxcy_ff, axcy_ff, aycx_ff;
   logic signed [DW-1:0] ax2_ff, ay2_ff;
   logic signed [CW-1:0] sx2_ff, sy2_ff;
   // stage 3: cross sums
   logic signed [SW-1:0] den_ff, na_ff, nb_ff;
   logic signed [DW-1:0] ax3_ff, ay3_ff;
   logic signed [CW-1:0] sx3_ff, sy3_ff;
   // stage 4: magnitudes and signs
   logic [MW-1:0] dm_ff, nam_ff, nbm_ff;
   logic [DW-1:0] axm_ff, aym_ff;
   logic dn_ff, nan_ff, nbn_ff, axn_ff, ayn_ff, dz_ff, naz_ff, nbz_ff;
   logic signed [CW-1:0] sx4_ff, sy4_ff;
   // stage 5: partial products and kind
   logic [PW-1:0] xl_ff, xh_ff, yl_ff, yh_ff;
   logic [MW-1:0] dm5_ff;
   side_type sdx5_ff, sdy5_ff;
   // stage 6: outputs
   logic [NW-1:0] nx_ff, ny_ff;
   logic [MW-1:0] dm6_ff;
   side_type sdx6_ff, sdy6_ff;

   logic [5:0] v_in;
   logic ua_in, ub_in;
   kind_type kind_in;

   assign v_in = {v_ff[4:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      ua_in = naz_ff || ((nan_ff == dn_ff) && (nam_ff <= dm_ff));
      ub_in = nbz_ff || ((nbn_ff == dn_ff) && (nbm_ff <= dm_ff));
      if (dz_ff) begin
         kind_in = KIND_NONE;
      end else if (ua_in && ub_in) begin
         kind_in = KIND_BOUNDED;
      end else begin
         kind_in = KIND_UNBOUNDED;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff  <= DW'($signed(in_word.first_end_x))   - DW'($signed(in_word.first_start_x));
      ay_ff  <= DW'($signed(in_word.first_end_y))   - DW'($signed(in_word.first_start_y));
      bx_ff  <= DW'($signed(in_word.other_start_x)) - DW'($signed(in_word.other_end_x));
      by_ff  <= DW'($signed(in_word.other_start_y)) - DW'($signed(in_word.other_end_y));
      cx_ff  <= DW'($signed(in_word.first_start_x)) - DW'($signed(in_word.other_start_x));
      cy_ff  <= DW'($signed(in_word.first_start_y)) - DW'($signed(in_word.other_start_y));
      sx1_ff <= in_word.first_start_x;
      sy1_ff <= in_word.first_start_y;

      aybx_ff <= ay_ff * bx_ff;
      axby_ff <= ax_ff * by_ff;
      bycx_ff <= by_ff * cx_ff;
      bxcy_ff <= bx_ff * cy_ff;
      axcy_ff <= ax_ff * cy_ff;
      aycx_ff <= ay_ff * cx_ff;
      ax2_ff  <= ax_ff;
      ay2_ff  <= ay_ff;
      sx2_ff  <= sx1_ff;
      sy2_ff  <= sy1_ff;

      den_ff <= SW'(aybx_ff) - SW'(axby_ff);
      na_ff  <= SW'(bycx_ff) - SW'(bxcy_ff);
      nb_ff  <= SW'(axcy_ff) - SW'(aycx_ff);
      ax3_ff <= ax2_ff;
      ay3_ff <= ay2_ff;
      sx3_ff <= sx2_ff;
      sy3_ff <= sy2_ff;

      dn_ff  <= den_ff[SW-1];
      nan_ff <= na_ff[SW-1];
      nbn_ff <= nb_ff[SW-1];
      axn_ff <= ax3_ff[DW-1];
      ayn_ff <= ay3_ff[DW-1];
      dz_ff  <= (den_ff == '0);
      naz_ff <= (na_ff == '0);
      nbz_ff <= (nb_ff == '0);
      dm_ff  <= MW'(den_ff[SW-1] ? -den_ff : den_ff);
      nam_ff <= MW'(na_ff[SW-1] ? -na_ff : na_ff);
      nbm_ff <= MW'(nb_ff[SW-1] ? -nb_ff : nb_ff);
      axm_ff <= ax3_ff[DW-1] ? -ax3_ff : ax3_ff;
      aym_ff <= ay3_ff[DW-1] ? -ay3_ff : ay3_ff;
      sx4_ff <= sx3_ff;
      sy4_ff <= sy3_ff;

      xl_ff  <= PW'(axm_ff) * PW'(nam_ff[DW-1:0]);
      xh_ff  <= PW'(axm_ff) * PW'(nam_ff[MW-1:DW]);
      yl_ff  <= PW'(aym_ff) * PW'(nam_ff[DW-1:0]);
      yh_ff  <= PW'(aym_ff) * PW'(nam_ff[MW-1:DW]);
      dm5_ff <= dm_ff;
      sdx5_ff.kind  <= kind_in;
      sdx5_ff.start <= sx4_ff;
      sdx5_ff.neg   <= axn_ff ^ nan_ff ^ dn_ff;
      sdy5_ff.kind  <= kind_in;
      sdy5_ff.start <= sy4_ff;
      sdy5_ff.neg   <= ayn_ff ^ nan_ff ^ dn_ff;

      nx_ff   <= NW'(xl_ff) + (NW'(xh_ff) << DW);
      ny_ff   <= NW'(yl_ff) + (NW'(yh_ff) << DW);
      dm6_ff  <= dm5_ff;
      sdx6_ff <= sdx5_ff;
      sdy6_ff <= sdy5_ff;
   end

   assign out_valid = v_ff[5];
   assign num_x     = nx_ff;
   assign num_y     = ny_ff;
   assign den_mag   = dm6_ff;
   assign side_x    = sdx6_ff;
   assign side_y    = sdy6_ff;

endmodule

[hw/rtl/lsi_div.sv]
module lsi_div import lsi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [NW-1:0]   num,
   input  logic [MW-1:0]   den,
   input  side_type        in_side,
   output logic            out_valid,
   output logic [QB-1:0]   quo,
   output logic [RW-1:0]   rem,
   output logic [MW-1:0]   den_out,
   output logic            big,
   output side_type        out_side
);

   logic            v_ff   [0:QB];
   logic [RW-1:0]   r_ff   [0:QB];
   logic [QB-1:0]   lo_ff  [0:QB];
   logic [QB-1:0]   q_ff   [0:QB];
   logic [MW-1:0]   d_ff   [0:QB];
   logic            big_ff [0:QB];
   side_type        s_ff   [0:QB];

   logic [RW-1:0]   r_in   [1:QB];
   logic            qb_in  [1:QB];

   // one quotient bit per stage, restoring
   always_comb begin
      logic [RW:0] t;
      logic [RW:0] dd;
      for (int i = 1; i <= QB; i++) begin
         t  = {r_ff[i-1], lo_ff[i-1][QB-1]};
         dd = {1'b0, d_ff[i-1]};
         qb_in[i] = (t >= dd);
         r_in[i]  = qb_in[i] ? RW'(t - dd) : RW'(t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QB; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= QB; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff[0]   <= RW'(num[NW-1:QB]);
      lo_ff[0]  <= num[QB-1:0];
      q_ff[0]   <= '0;
      d_ff[0]   <= den;
      big_ff[0] <= ((NW+1)'(num) >= {den, QB'(0)});
      s_ff[0]   <= in_side;
      for (int i = 1; i <= QB; i++) begin
         r_ff[i]   <= r_in[i];
         lo_ff[i]  <= lo_ff[i-1] << 1;
         q_ff[i]   <= {q_ff[i-1][QB-2:0], qb_in[i]};
         d_ff[i]   <= d_ff[i-1];
         big_ff[i] <= big_ff[i-1];
         s_ff[i]   <= s_ff[i-1];
      end
   end

   assign out_valid = v_ff[QB];
   assign quo       = q_ff[QB];
   assign rem       = r_ff[QB];
   assign den_out   = d_ff[QB];
   assign big       = big_ff[QB];
   assign out_side  = s_ff[QB];

endmodule

[hw/rtl/lsi_place.sv]
module lsi_place import lsi_pkg::*; (
   input  logic                 clock,
   input  logic [QB-1:0]        quo,
   input  logic [RW-1:0]        rem,
   input  logic [MW-1:0]        den,
   input  logic                 big,
   input  side_type             side,
   output logic signed [CW-1:0] point,
   output logic                 sat
);

   localparam int TW = QB + 2;
   localparam logic signed [TW-1:0] HI = TW'((64'(1) << (CW - 1)) - 64'(1));
   localparam logic signed [TW-1:0] LO = -HI - TW'(1);

   logic [QB-1:0]        mag_ff;
   logic                 neg_ff;
   logic signed [CW-1:0] start_ff;
   logic signed [CW-1:0] pt_ff;
   logic                 sat_ff;

   logic                 rnd_in;
   logic [QB:0]          q1_in;
   logic signed [TW-1:0] tot_in;

   always_comb begin
      rnd_in = ({rem, 1'b0} >= {1'b0, den});
      q1_in  = (QB+1)'(quo) + (QB+1)'(rnd_in);
      tot_in = neg_ff ? TW'(start_ff) - TW'({1'b0, mag_ff})
                      : TW'(start_ff) + TW'({1'b0, mag_ff});
   end

   // round, clamp, then add and saturate
   always_ff @(posedge clock) begin
      mag_ff   <= (big || (q1_in > MAG_LIMIT)) ? QB'(MAG_LIMIT) : QB'(q1_in);
      neg_ff   <= side.neg;
      start_ff <= side.start;
      if (tot_in > HI) begin
         pt_ff  <= CW'(HI);
         sat_ff <= 1'b1;
      end else if (tot_in < LO) begin
         pt_ff  <= CW'(LO);
         sat_ff <= 1'b1;
      end else begin
         pt_ff  <= CW'(tot_in);
         sat_ff <= 1'b0;
      end
   end

   assign point = pt_ff;
   assign sat   = sat_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import lsi_pkg::*;

   localparam int LATENCY   = 43;
   localparam int WDOG_MAX  = 2000;
   localparam int N_RANDOM  = 450;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   line_segment_intersect u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   req_type pending_words[$];
   rsp_type expected_points[$];
   int      n_errors = 0;
   int      n_sent = 0;
   int      n_seen = 0;
   int      n_sat = 0;
   int      n_kind[3] = '{0, 0, 0};
   int      idle_cycles = 0;
   bit      quiet_stretch = 1'b0;
   bit      stim_done = 1'b0;

   task automatic report(input string what, input logic [127:0] got,
                         input logic [127:0] want);
      $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, n_seen);
      n_errors++;
   endtask

   function automatic logic signed [255:0] round_div(input logic signed [255:0] num,
                                                     input logic signed [255:0] den);
      logic [255:0] an, ad, q, r;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = an / ad;
      r = an % ad;
      if ((r << 1) >= ad) q = q + 1;
      return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [CW-1:0] place_coord(
         input logic signed [CW-1:0] org, input logic signed [255:0] delta,
         input logic signed [255:0] num, input logic signed [255:0] den,
         inout bit sat);
      logic signed [255:0] off, total, lim, hi, lo;
      lim = 256'sd1 <<< (CW + 1);
      off = round_div(delta * num, den);
      if (off > lim) off = lim;
      if (off < -lim) off = -lim;
      total = org + off;
      hi = (256'sd1 <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (total > hi) begin sat = 1; return hi[CW-1:0]; end
      if (total < lo) begin sat = 1; return lo[CW-1:0]; end
      return total[CW-1:0];
   endfunction

   function automatic bit unit_range(input logic signed [255:0] num,
                                     input logic signed [255:0] den);
      if (num == 0) return 1;
      if ((num < 0) != (den < 0)) return 0;
      return (num < 0 ? -num : num) <= (den < 0 ? -den : den);
   endfunction

   function automatic rsp_type predict_crossing(input req_type w);
      logic signed [255:0] ax, ay, bx, by, cx, cy, den, na, nb;
      rsp_type o;
      bit sat;
      o = '0;
      sat = 0;
      ax = $signed(256'(signed'(w.first_end_x))) - $signed(256'(signed'(w.first_start_x)));
      ay = $signed(256'(signed'(w.first_end_y))) - $signed(256'(signed'(w.first_start_y)));
      bx = $signed(256'(signed'(w.other_start_x))) - $signed(256'(signed'(w.other_end_x)));
      by = $signed(256'(signed'(w.other_start_y))) - $signed(256'(signed'(w.other_end_y)));
      cx = $signed(256'(signed'(w.first_start_x))) - $signed(256'(signed'(w.other_start_x)));
      cy = $signed(256'(signed'(w.first_start_y))) - $signed(256'(signed'(w.other_start_y)));
      den = ay * bx - ax * by;
      o.kind = KIND_NONE;
      if (den == 0) return o;
      na = by * cx - bx * cy;
      nb = ax * cy - ay * cx;
      o.point_x = place_coord(w.first_start_x, ax, na, den, sat);
      o.point_y = place_coord(w.first_start_y, ay, na, den, sat);
      o.kind = (unit_range(na, den) && unit_range(nb, den)) ? KIND_BOUNDED : KIND_UNBOUNDED;
      o.point_valid = 1'b1;
      o.point_saturated = sat;
      return o;
   endfunction

   function automatic logic [CW-1:0] rand_coord(input int style);
      case (style)
         0: rand_coord = $urandom;
         1: rand_coord = $signed($urandom_range(0, 'h1FFFFF)) - 'h100000;
         2: rand_coord = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                              : 32'h80000000 + $urandom_range(0, 3);
         default: rand_coord = $signed($urandom_range(0, 16)) - 8;
      endcase
   endfunction

   function automatic req_type word_of(input logic [CW-1:0] a, b, c, d, e, f, g, h);
      req_type w;
      w.first_start_x = a; w.first_start_y = b; w.first_end_x = c; w.first_end_y = d;
      w.other_start_x = e; w.other_start_y = f; w.other_end_x = g; w.other_end_y = h;
      return w;
   endfunction

   initial begin
      req_type w;
      int style;
      int k;
      localparam logic [CW-1:0] MAXV = 32'h7FFFFFFF;
      localparam logic [CW-1:0] MINV = 32'h80000000;
      localparam logic [CW-1:0] ONE = 32'h00010000;
      // crossing inside both segments, then outside, then parallel
      pending_words.push_back(word_of(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));
      pending_words.push_back(word_of(0, 0, ONE, ONE, 5*ONE, 0, 5*ONE, ONE));
      pending_words.push_back(word_of(0, 0, ONE, ONE, 0, ONE, ONE, 2*ONE));
      // zero-length segments
      pending_words.push_back(word_of(ONE, ONE, ONE, ONE, 0, 0, ONE, 0));
      pending_words.push_back(word_of(0, 0, 0, 0, 0, 0, 0, 0));
      // touching at endpoints
      pending_words.push_back(word_of(0, 0, ONE, 0, ONE, 0, ONE, ONE));
      // extremes of the range
      pending_words.push_back(word_of(MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, MINV));
      pending_words.push_back(word_of(MAXV, MAXV, MINV, MINV, MAXV, MINV, MINV, MAXV));
      pending_words.push_back(word_of(MINV, MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV));
      pending_words.push_back(word_of('1, '1, '1, '1, '1, '1, '1, '1));
      // nearly parallel: huge offset saturates
      pending_words.push_back(word_of(0, 0, MAXV, 1, 0, 1, MAXV, 2));
      pending_words.push_back(word_of(MINV, 0, 0, 1, MINV, 1, 0, 3));
      pending_words.push_back(word_of(0, 0, 1, 0, 0, 1, 2, MAXV));
      pending_words.push_back(word_of(0, MAXV, 1, MAXV, MINV, MINV, MINV + 1, MAXV));
      for (k = 0; k < N_RANDOM; k++) begin
         style = $urandom_range(0, 3);
         w = word_of(rand_coord(style), rand_coord(style), rand_coord(style),
                     rand_coord(style), rand_coord(style), rand_coord(style),
                     rand_coord(style), rand_coord(style));
         // bias a share toward parallel and shared-endpoint cases
         if ($urandom_range(0, 9) == 0) begin
            w.other_end_x = w.other_start_x + (w.first_end_x - w.first_start_x);
            w.other_end_y = w.other_start_y + (w.first_end_y - w.first_start_y);
         end else if ($urandom_range(0, 9) == 0) begin
            w.other_start_x = w.first_end_x;
            w.other_start_y = w.first_end_y;
         end
         pending_words.push_back(w);
      end
   end

   task automatic w_drive(input req_type w);
      req_word <= w;
      start <= 1'b1;
      expected_points.push_back(predict_crossing(w));
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) n_sent++;
         if (n_sent == 150) quiet_stretch = 1'b1;
         if (n_sent == 300) quiet_stretch = 1'b0;
         if (start && busy) begin
            // hold the word until taken
         end else if (pending_words.size() > 0 &&
                      (quiet_stretch || $urandom_range(0, 99) >= 32)) begin
            w_drive(pending_words.pop_front());
         end else begin
            start <= 1'b0;
            if (pending_words.size() == 0) stim_done = 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         n_seen++;
         if (expected_points.size() == 0) begin
            report("unexpected word", rsp_word, 0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_word.kind !== want.kind) report("kind", rsp_word.kind, want.kind);
            if (rsp_word.point_x !== want.point_x)
               report("point_x", rsp_word.point_x, want.point_x);
            if (rsp_word.point_y !== want.point_y)
               report("point_y", rsp_word.point_y, want.point_y);
            if (rsp_word.point_valid !== want.point_valid)
               report("point_valid", rsp_word.point_valid, want.point_valid);
            if (rsp_word.point_saturated !== want.point_saturated)
               report("point_saturated", rsp_word.point_saturated, want.point_saturated);
            if (want.kind <= KIND_UNBOUNDED) n_kind[want.kind]++;
            if (want.point_saturated) n_sat++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("timeout with %0d words outstanding", expected_points.size());
            $display("FAIL line_segment_intersect");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (stim_done);
      wait (expected_points.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
      $display("covered %0d words: %0d parallel, %0d bounded, %0d unbounded, %0d clamped",
               n_seen, n_kind[0], n_kind[1], n_kind[2], n_sat);
      if (n_errors == 0 && expected_points.size() == 0) begin
         $display("PASS line_segment_intersect");
      end else begin
         $display("FAIL line_segment_intersect");
      end
      $finish;
   end

endmodule
